### rtl/core/riec_pkg.sv
package riec_pkg;

    // Port widths
    localparam int S_TDATA_W = 56;  // px, py, pz, valid_req, surface_class, zero fill
    localparam int M_TDATA_W = 24;  // row, col, label
    localparam int CFG_AW    = 3;
    localparam int CFG_DW    = 16;

    // Configuration register indexes
    localparam logic [CFG_AW-1:0] REG_ROWS_IN_USE       = 3'd0;
    localparam logic [CFG_AW-1:0] REG_COLS_IN_USE       = 3'd1;
    localparam logic [CFG_AW-1:0] REG_VERTICAL_FACTOR   = 3'd2;
    localparam logic [CFG_AW-1:0] REG_HORIZONTAL_FACTOR = 3'd3;
    localparam logic [CFG_AW-1:0] REG_BASE_ERROR        = 3'd4;
    localparam logic [CFG_AW-1:0] REG_MAX_THRESHOLD     = 3'd5;

    // Register values after reset
    localparam logic [10:0] RST_ROWS_IN_USE = 11'd64;
    localparam logic [11:0] RST_COLS_IN_USE = 12'd1024;
    localparam logic [15:0] RST_FACTOR      = 16'd256;
    localparam logic [15:0] RST_BASE_ERROR  = 16'd30;
    localparam logic [15:0] RST_MAX_THRESH  = 16'd200;

    // Request kind on tuser
    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    // Surface classes
    localparam logic [1:0] CLS_ROAD = 2'd1;
    localparam logic [1:0] CLS_HIGH = 2'd2;

    // Square root pipeline depth (two result bits per stage)
    localparam int SQ_LAT = 8;

    typedef enum logic [2:0] {
        LBL_INVALID    = 3'd0,
        LBL_GROUND     = 3'd1,
        LBL_BACKGROUND = 3'd2,
        LBL_EDGE       = 3'd3,
        LBL_UNKNOWN    = 3'd4
    } label_t;

    // One stored pixel: p[0] = x, p[1] = y, p[2] = z
    typedef struct packed {
        logic [1:0]       sclass;
        logic             vld;
        logic [2:0][15:0] p;
    } ent_t;

endpackage

### rtl/core/riec_linebuf.sv
module riec_linebuf #(
    parameter int MAX_COLS = 2048
) (
    input  logic                        aclk,
    input  logic                        wr_en,
    input  logic                        wr_bank,
    input  logic [$clog2(MAX_COLS)-1:0] wr_col,
    input  riec_pkg::ent_t              wr_data,
    input  logic                        rd_prev_bank,
    input  logic                        rd_up_bank,
    input  logic [$clog2(MAX_COLS)-1:0] rd_col,
    output riec_pkg::ent_t              rd_center,
    output riec_pkg::ent_t              rd_right,
    output riec_pkg::ent_t              rd_up
);
    import riec_pkg::*;

    localparam int CW    = $clog2(MAX_COLS);
    localparam int HALF  = (MAX_COLS + 1) / 2;
    localparam int DEPTH = 2 * HALF;
    localparam int AW    = $clog2(DEPTH);

    // Even and odd columns live in separate arrays so c and c+1 read together
    ent_t mem_e [DEPTH];
    ent_t mem_o [DEPTH];

    logic [CW:0]   col_e;
    logic [CW:0]   col_o;
    logic [AW-1:0] wa;
    logic [AW-1:0] ea_a, ea_b, oa_a, oa_b;
    logic          we_e, we_o;
    ent_t          ea_q, eb_q, oa_q, ob_q;
    logic          par_q;

    function automatic logic [AW-1:0] slot_addr(logic bank, logic [CW:0] col);
        logic [CW:0] h;
        h = col >> 1;
        if (int'(h) >= HALF) h = '0;  // past last column: unused read
        return bank ? AW'(HALF) + AW'(h) : AW'(h);
    endfunction

    // Address generation
    always_comb begin
        col_e = rd_col[0] ? {1'b0, rd_col} + 1'b1 : {1'b0, rd_col};
        col_o = rd_col[0] ? {1'b0, rd_col} : {1'b0, rd_col} + 1'b1;
        ea_a  = slot_addr(rd_prev_bank, col_e);
        ea_b  = slot_addr(rd_up_bank, col_e);
        oa_a  = slot_addr(rd_prev_bank, col_o);
        oa_b  = slot_addr(rd_up_bank, col_o);
        wa    = slot_addr(wr_bank, {1'b0, wr_col});
        we_e  = wr_en && !wr_col[0];
        we_o  = wr_en && wr_col[0];
    end

    // Even bank: write-first so a just-written pixel is seen on short rows
    always_ff @(posedge aclk) begin
        if (we_e) mem_e[wa] <= wr_data;
        ea_q <= (we_e && wa == ea_a) ? wr_data : mem_e[ea_a];
        eb_q <= (we_e && wa == ea_b) ? wr_data : mem_e[ea_b];
    end

    // Odd bank
    always_ff @(posedge aclk) begin
        if (we_o) mem_o[wa] <= wr_data;
        oa_q <= (we_o && wa == oa_a) ? wr_data : mem_o[oa_a];
        ob_q <= (we_o && wa == oa_b) ? wr_data : mem_o[oa_b];
    end

    always_ff @(posedge aclk) begin
        par_q <= rd_col[0];
    end

    // Sort by column parity
    assign rd_center = par_q ? oa_q : ea_q;
    assign rd_right  = par_q ? ea_q : oa_q;
    assign rd_up     = par_q ? ob_q : eb_q;

endmodule

### rtl/core/riec_isqrt.sv
module riec_isqrt (
    input  logic        aclk,
    input  logic        en,
    input  logic [31:0] rad,
    output logic [15:0] root
);
    import riec_pkg::*;

    typedef struct packed {
        logic [16:0] rem;
        logic [15:0] res;
    } sq_state_t;

    // One digit-by-digit step: bring in two radicand bits, try one root bit
    function automatic sq_state_t sq_iter(sq_state_t s, logic [1:0] b);
        logic [18:0] sh;
        logic [18:0] trial;
        sq_state_t   o;
        sh    = {s.rem, b};
        trial = {1'b0, s.res, 2'b01};
        if (sh >= trial) begin
            o.rem = 17'(sh - trial);
            o.res = {s.res[14:0], 1'b1};
        end else begin
            o.rem = sh[16:0];
            o.res = {s.res[14:0], 1'b0};
        end
        return o;
    endfunction

    sq_state_t   st_reg  [SQ_LAT];
    logic [31:0] rad_reg [SQ_LAT];

    // First stage takes the top four radicand bits
    always_ff @(posedge aclk) begin
        if (en) begin
            st_reg[0]  <= sq_iter(sq_iter('0, rad[31:30]), rad[29:28]);
            rad_reg[0] <= rad;
        end
    end

    for (genvar k = 1; k < SQ_LAT; k++) begin : g_stage
        always_ff @(posedge aclk) begin
            if (en) begin
                st_reg[k]  <= sq_iter(sq_iter(st_reg[k-1], rad_reg[k-1][31-4*k -: 2]),
                                      rad_reg[k-1][29-4*k -: 2]);
                rad_reg[k] <= rad_reg[k-1];
            end
        end
    end

    assign root = st_reg[SQ_LAT-1].res;

endmodule

### rtl/core/range_image_edge_classifier_core.sv
// Channel  | Dir | Handshake          | Contents
// s_       | in  | s_tvalid/s_tready  | pixel or flush request, kind on tuser
// m_       | out | m_tvalid/m_tready  | labeled pixel, frame end on tlast
// cfg_     | in  | cfg_valid/cfg_ready| register index and write data
//
// One request per cycle sustained while m_ is not stalled; a label is presented
// once the request completing it passes 16 register stages (4 front, 8 square
// root, 3 threshold, output; the first loads on the accepting edge).
// Line store reads are prefetched from the next position.
// Reset is synchronous active low; clears counters, valid bits, presets cfg regs.
// Back pressure on m_ freezes the whole pipeline; s_tready follows it.
module range_image_edge_classifier_core #(
    parameter int MAX_COLS = 2048,
    parameter int MAX_ROWS = 1024
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // [15:0] px, [31:16] py, [47:32] pz, [48] valid_req, [50:49] surface_class
    input  logic [riec_pkg::S_TDATA_W-1:0] s_tdata,
    // [0] opcode
    input  logic [0:0]                     s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [9:0] row, [20:10] col, [23:21] label
    output logic [riec_pkg::M_TDATA_W-1:0] m_tdata,
    output logic                           m_tlast,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [riec_pkg::CFG_AW-1:0]    cfg_addr,
    input  logic [riec_pkg::CFG_DW-1:0]    cfg_wdata
);
    import riec_pkg::*;

    localparam int CW  = $clog2(MAX_COLS);
    localparam int CEW = $clog2(MAX_COLS + 1);
    localparam int RW  = $clog2(MAX_ROWS + 1);

    typedef struct packed {
        logic [9:0]  row;
        logic [10:0] col;
        logic        last;
    } pos_t;

    typedef struct packed {
        pos_t       pos;
        ent_t       c;
        ent_t [3:0] nb;   // up, down, left, right
        logic [3:0] has;
    } st1_t;

    typedef struct packed {
        pos_t                   pos;
        label_t                 pre;
        logic [3:0]             use_nb;
        logic [3:0][2:0][15:0]  ad;
        logic [15:0]            ax;
        logic [15:0]            ay;
    } st2_t;

    typedef struct packed {
        pos_t                   pos;
        label_t                 pre;
        logic [3:0]             use_nb;
        logic [3:0][2:0][31:0]  sq;
        logic [31:0]            x2;
        logic [31:0]            y2;
    } st3_t;

    typedef struct packed {
        pos_t             pos;
        label_t           pre;
        logic [3:0][33:0] dsq;
        logic [31:0]      rsq;
    } st4_t;

    typedef struct packed {
        pos_t        pos;
        label_t      pre;
        logic [33:0] mv;
        logic [33:0] mh;
    } meta_t;

    typedef struct packed {
        meta_t       m;
        logic [23:0] tv;
        logic [23:0] th;
    } pa_t;

    typedef struct packed {
        meta_t       m;
        logic [15:0] tv;
        logic [15:0] th;
    } pb_t;

    typedef struct packed {
        meta_t       m;
        logic [31:0] tv2;
        logic [31:0] th2;
    } pc_t;

    // Configuration registers
    logic [10:0] rows_cfg_reg;
    logic [11:0] cols_cfg_reg;
    logic [15:0] vfac_reg, hfac_reg, base_reg, maxt_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rows_cfg_reg <= RST_ROWS_IN_USE;
            cols_cfg_reg <= RST_COLS_IN_USE;
            vfac_reg     <= RST_FACTOR;
            hfac_reg     <= RST_FACTOR;
            base_reg     <= RST_BASE_ERROR;
            maxt_reg     <= RST_MAX_THRESH;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_addr)
                REG_ROWS_IN_USE:       rows_cfg_reg <= cfg_wdata[10:0];
                REG_COLS_IN_USE:       cols_cfg_reg <= cfg_wdata[11:0];
                REG_VERTICAL_FACTOR:   vfac_reg     <= cfg_wdata;
                REG_HORIZONTAL_FACTOR: hfac_reg     <= cfg_wdata;
                REG_BASE_ERROR:        base_reg     <= cfg_wdata;
                REG_MAX_THRESHOLD:     maxt_reg     <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign cfg_ready = 1'b1;

    // Effective frame geometry
    logic [RW-1:0]  rows_eff;
    logic [CEW-1:0] cols_eff;

    always_comb begin
        if (rows_cfg_reg == '0)            rows_eff = RW'(1);
        else if (rows_cfg_reg > MAX_ROWS)  rows_eff = RW'(MAX_ROWS);
        else                               rows_eff = RW'(rows_cfg_reg);
        if (cols_cfg_reg == '0)            cols_eff = CEW'(1);
        else if (cols_cfg_reg > MAX_COLS)  cols_eff = CEW'(MAX_COLS);
        else                               cols_eff = CEW'(cols_cfg_reg);
    end

    // Input request decode
    ent_t  in_ent;
    logic  in_flush;
    logic  pipe_en;
    logic  acc, act_px, act_fl, emit, wrap;
    logic [CW:0] col_inc;

    assign in_ent.p[0]  = s_tdata[15:0];
    assign in_ent.p[1]  = s_tdata[31:16];
    assign in_ent.p[2]  = s_tdata[47:32];
    assign in_ent.vld   = s_tdata[48];
    assign in_ent.sclass = s_tdata[50:49];
    assign in_flush     = (s_tuser[0] == OP_FLUSH);

    logic          m_tvalid_reg;
    logic [CW-1:0] col_reg, col_next;
    logic [RW-1:0] row_reg, row_next;

    assign pipe_en  = !m_tvalid_reg || m_tready;
    assign s_tready = pipe_en;
    assign acc      = s_tvalid && s_tready;
    assign col_inc  = {1'b0, col_reg} + 1'b1;
    assign wrap     = (col_inc >= cols_eff);
    assign act_px   = acc && !in_flush && (row_reg < rows_eff);
    assign act_fl   = acc && in_flush && (row_reg >= rows_eff);
    assign emit     = (act_px && row_reg != '0) || act_fl;

    // Position counters
    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        if (act_px || act_fl) begin
            if (wrap) begin
                col_next = '0;
                row_next = act_px ? row_reg + 1'b1 : '0;
            end else begin
                col_next = col_inc[CW-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // Line store, read one position ahead
    ent_t buf_center, buf_right, buf_up;
    ent_t left_reg;

    riec_linebuf #(
        .MAX_COLS (MAX_COLS)
    ) u_linebuf (
        .aclk         (aclk),
        .wr_en        (act_px),
        .wr_bank      (row_reg[0]),
        .wr_col       (col_reg),
        .wr_data      (in_ent),
        .rd_prev_bank (~row_next[0]),
        .rd_up_bank   (row_next[0]),
        .rd_col       (col_next),
        .rd_center    (buf_center),
        .rd_right     (buf_right),
        .rd_up        (buf_up)
    );

    // Left neighbor is the previous center of the same row
    always_ff @(posedge aclk) begin
        if (act_px || act_fl) left_reg <= buf_center;
    end

    // Stage 1: gather neighborhood
    st1_t st1_next, st1_reg;

    always_comb begin
        st1_next.pos.row  = 10'(row_reg - 1'b1);
        st1_next.pos.col  = 11'(col_reg);
        st1_next.pos.last = act_fl && wrap;
        st1_next.c        = buf_center;
        st1_next.nb[0]    = buf_up;
        st1_next.nb[1]    = in_ent;
        st1_next.nb[2]    = left_reg;
        st1_next.nb[3]    = buf_right;
        st1_next.has[0]   = (row_reg > RW'(1));
        st1_next.has[1]   = !in_flush;
        st1_next.has[2]   = (col_reg != '0);
        st1_next.has[3]   = !wrap;
    end

    function automatic logic [15:0] abs_diff(logic [15:0] a, logic [15:0] b);
        logic [16:0] d;
        logic [16:0] n;
        d = {a[15], a} - {b[15], b};
        n = -d;
        return d[16] ? n[15:0] : d[15:0];
    endfunction

    function automatic logic [15:0] abs16(logic [15:0] a);
        return a[15] ? (~a + 1'b1) : a;
    endfunction

    // Stage 2: blocked count, early label, coordinate differences
    st2_t       st2_next, st2_reg;
    logic [3:0] blk;

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            blk[k] = !st1_reg.nb[k].vld || st1_reg.nb[k].sclass == CLS_ROAD ||
                     st1_reg.nb[k].sclass == CLS_HIGH;
            for (int j = 0; j < 3; j++) begin
                st2_next.ad[k][j] = abs_diff(st1_reg.c.p[j], st1_reg.nb[k].p[j]);
            end
        end
        st2_next.pos    = st1_reg.pos;
        st2_next.use_nb = st1_reg.has & ~blk;
        st2_next.ax     = abs16(st1_reg.c.p[0]);
        st2_next.ay     = abs16(st1_reg.c.p[1]);
        if (!st1_reg.c.vld)                          st2_next.pre = LBL_INVALID;
        else if (st1_reg.c.sclass == CLS_ROAD)       st2_next.pre = LBL_GROUND;
        else if (st1_reg.c.sclass == CLS_HIGH)       st2_next.pre = LBL_BACKGROUND;
        else if ($countones(st1_reg.has & blk) > 1)  st2_next.pre = LBL_EDGE;
        else                                         st2_next.pre = LBL_UNKNOWN;
    end

    // Stage 3: squares
    st3_t st3_next, st3_reg;

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            for (int j = 0; j < 3; j++) begin
                st3_next.sq[k][j] = st2_reg.ad[k][j] * st2_reg.ad[k][j];
            end
        end
        st3_next.pos    = st2_reg.pos;
        st3_next.pre    = st2_reg.pre;
        st3_next.use_nb = st2_reg.use_nb;
        st3_next.x2     = st2_reg.ax * st2_reg.ax;
        st3_next.y2     = st2_reg.ay * st2_reg.ay;
    end

    // Stage 4: squared distances, squared planar range
    st4_t st4_next, st4_reg;

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            st4_next.dsq[k] = st3_reg.use_nb[k] ?
                34'(st3_reg.sq[k][0]) + 34'(st3_reg.sq[k][1]) + 34'(st3_reg.sq[k][2]) :
                34'd0;
        end
        st4_next.pos = st3_reg.pos;
        st4_next.pre = st3_reg.pre;
        st4_next.rsq = st3_reg.x2 + st3_reg.y2;
    end

    // Stage 5: per-direction maximum, then ride along with the square root
    meta_t meta_next;
    meta_t dly_reg [SQ_LAT];

    always_comb begin
        meta_next.pos = st4_reg.pos;
        meta_next.pre = st4_reg.pre;
        meta_next.mv  = (st4_reg.dsq[0] > st4_reg.dsq[1]) ? st4_reg.dsq[0] : st4_reg.dsq[1];
        meta_next.mh  = (st4_reg.dsq[2] > st4_reg.dsq[3]) ? st4_reg.dsq[2] : st4_reg.dsq[3];
    end

    logic [15:0] rng;

    riec_isqrt u_isqrt (
        .aclk (aclk),
        .en   (pipe_en),
        .rad  (st4_reg.rsq),
        .root (rng)
    );

    // Threshold stages: scale, clamp, square
    pa_t pa_next, pa_reg;
    pb_t pb_next, pb_reg;
    pc_t pc_next, pc_reg;
    logic [31:0] pv, ph;

    function automatic logic [15:0] clamp_t(logic [23:0] t, logic [15:0] lo, logic [15:0] hi);
        logic [23:0] u;
        u = (t < {8'd0, lo}) ? {8'd0, lo} : t;
        return (u > {8'd0, hi}) ? hi : u[15:0];
    endfunction

    always_comb begin
        pv          = vfac_reg * rng;
        ph          = hfac_reg * rng;
        pa_next.m   = dly_reg[SQ_LAT-1];
        pa_next.tv  = pv[31:8];
        pa_next.th  = ph[31:8];
        pb_next.m   = pa_reg.m;
        pb_next.tv  = clamp_t(pa_reg.tv, base_reg, maxt_reg);
        pb_next.th  = clamp_t(pa_reg.th, base_reg, maxt_reg);
        pc_next.m   = pb_reg.m;
        pc_next.tv2 = pb_reg.tv * pb_reg.tv;
        pc_next.th2 = pb_reg.th * pb_reg.th;
    end

    // Final label
    label_t lbl;

    always_comb begin
        lbl = pc_reg.m.pre;
        if (pc_reg.m.pre == LBL_UNKNOWN &&
            (pc_reg.m.mv >= {2'b00, pc_reg.tv2} || pc_reg.m.mh >= {2'b00, pc_reg.th2})) begin
            lbl = LBL_EDGE;
        end
    end

    // Valid bits
    logic              v1_reg, v2_reg, v3_reg, v4_reg, va_reg, vb_reg, vc_reg;
    logic [SQ_LAT-1:0] dly_v_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg       <= 1'b0;
            v2_reg       <= 1'b0;
            v3_reg       <= 1'b0;
            v4_reg       <= 1'b0;
            dly_v_reg    <= '0;
            va_reg       <= 1'b0;
            vb_reg       <= 1'b0;
            vc_reg       <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else if (pipe_en) begin
            v1_reg       <= emit;
            v2_reg       <= v1_reg;
            v3_reg       <= v2_reg;
            v4_reg       <= v3_reg;
            dly_v_reg    <= {dly_v_reg[SQ_LAT-2:0], v4_reg};
            va_reg       <= dly_v_reg[SQ_LAT-1];
            vb_reg       <= va_reg;
            vc_reg       <= vb_reg;
            m_tvalid_reg <= vc_reg;
        end
    end

    // Payload registers
    logic [M_TDATA_W-1:0] m_tdata_reg;
    logic                 m_tlast_reg;

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            st1_reg    <= st1_next;
            st2_reg    <= st2_next;
            st3_reg    <= st3_next;
            st4_reg    <= st4_next;
            dly_reg[0] <= meta_next;
            for (int i = 1; i < SQ_LAT; i++) begin
                dly_reg[i] <= dly_reg[i-1];
            end
            pa_reg      <= pa_next;
            pb_reg      <= pb_next;
            pc_reg      <= pc_next;
            m_tdata_reg <= {lbl, pc_reg.m.pos.col, pc_reg.m.pos.row};
            m_tlast_reg <= pc_reg.m.pos.last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    // Checks
    a_frame_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (act_fl && wrap) |=> (row_reg == '0 && col_reg == '0))
        else $error("counters not cleared at frame end");

    a_row_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        row_reg <= RW'(MAX_ROWS))
        else $error("row counter beyond frame");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !pipe_en |=> ($stable(dly_v_reg) && $stable(vc_reg) && m_tvalid_reg))
        else $error("pipeline moved while stalled");

endmodule

### dv/range_image_edge_classifier_core_test.sv
`timescale 1ns / 1ps

module range_image_edge_classifier_core_test;
    import riec_pkg::*;

    localparam int NCOLS      = 2048;
    localparam int NROWS      = 1024;
    localparam int DRAIN_WAIT = 40;     // label latency is 16 register stages
    localparam int IDLE_LIMIT = 20000;
    localparam int ITEM_GOAL  = 1000;

    // One expected or observed label
    typedef struct packed {
        logic [9:0]  row;
        logic [10:0] col;
        label_t      lbl;
        logic        last;
    } label_rec_t;

    // Shadow of the classifier: line store, position counters, registers
    class label_scoreboard;
        logic [50:0]  line_mem [2*NCOLS];
        int unsigned  row_cnt, col_cnt;
        int unsigned  rows_reg, cols_reg, vfac, hfac, base_err, max_thr;
        label_rec_t   pending [$];
        int           mismatches;

        function new();
            foreach (line_mem[i]) line_mem[i] = '0;
            row_cnt = 0; col_cnt = 0;
            rows_reg = RST_ROWS_IN_USE; cols_reg = RST_COLS_IN_USE;
            vfac = RST_FACTOR; hfac = RST_FACTOR;
            base_err = RST_BASE_ERROR; max_thr = RST_MAX_THRESH;
            mismatches = 0;
        endfunction

        function void set_reg(logic [CFG_AW-1:0] idx, logic [15:0] val);
            case (idx)
                REG_ROWS_IN_USE:       rows_reg = val[10:0];
                REG_COLS_IN_USE:       cols_reg = val[11:0];
                REG_VERTICAL_FACTOR:   vfac = val;
                REG_HORIZONTAL_FACTOR: hfac = val;
                REG_BASE_ERROR:        base_err = val;
                REG_MAX_THRESHOLD:     max_thr = val;
                default: ;
            endcase
        endfunction

        // Append one expected label at the tail of the queue
        function void queue_label(label_rec_t rec);
            pending = {pending, rec};
        endfunction

        function int unsigned slot(int unsigned r, int unsigned c);
            return (r & 1) * NCOLS + (c % NCOLS);
        endfunction

        function longint coord(logic [50:0] e, int k);
            return longint'($signed(e[16*k +: 16]));
        endfunction

        function bit blocked(logic [50:0] e);
            return !e[48] || e[50:49] == CLS_ROAD || e[50:49] == CLS_HIGH;
        endfunction

        function longint unsigned dist_sq(logic [50:0] a, logic [50:0] b);
            longint unsigned s;
            longint d;
            s = 0;
            for (int k = 0; k < 3; k++) begin
                d = coord(a, k) - coord(b, k);
                s += longint'(d * d);
            end
            return s;
        endfunction

        // Bitwise integer square root, floor
        function longint unsigned int_root(longint unsigned v);
            longint unsigned res, b;
            res = 0;
            b = 64'd1 << 62;
            while (b > v) b >>= 2;
            while (b != 0) begin
                if (v >= res + b) begin
                    v -= res + b;
                    res = (res >> 1) + b;
                end else begin
                    res >>= 1;
                end
                b >>= 2;
            end
            return res;
        endfunction

        // Clamp order matters: the upper clamp wins when the two cross
        function longint unsigned dist_limit(int unsigned fac, longint unsigned rng);
            longint unsigned t;
            t = (longint'(fac) * rng) >> 8;
            if (t < base_err) t = base_err;
            if (t > max_thr) t = max_thr;
            return t;
        endfunction

        // nb order: up, down, left, right
        function label_t classify(logic [50:0] c, logic [50:0] nb [4], bit has [4]);
            int unsigned cnt;
            longint unsigned mv, mh, d, rng, t;
            cnt = 0; mv = 0; mh = 0;
            if (!c[48]) return LBL_INVALID;
            if (c[50:49] == CLS_ROAD) return LBL_GROUND;
            if (c[50:49] == CLS_HIGH) return LBL_BACKGROUND;
            for (int k = 0; k < 4; k++)
                if (has[k] && blocked(nb[k])) cnt++;
            if (cnt > 1) return LBL_EDGE;
            for (int k = 0; k < 4; k++) begin
                if (has[k] && !blocked(nb[k])) begin
                    d = dist_sq(c, nb[k]);
                    if (k < 2) begin
                        if (d > mv) mv = d;
                    end else if (d > mh) begin
                        mh = d;
                    end
                end
            end
            rng = int_root(longint'(coord(c, 0) * coord(c, 0))
                         + longint'(coord(c, 1) * coord(c, 1)));
            t = dist_limit(vfac, rng);
            if (mv >= t * t) return LBL_EDGE;
            t = dist_limit(hfac, rng);
            if (mh >= t * t) return LBL_EDGE;
            return LBL_UNKNOWN;
        endfunction

        function label_rec_t label_pixel(int unsigned lr, int unsigned c, int unsigned cols,
                                         bit has_dn, logic [50:0] dn, bit last);
            logic [50:0] nb [4];
            bit          has [4];
            label_rec_t  rec;
            nb[0] = line_mem[slot(lr + 1, c)];  has[0] = lr > 0;
            nb[1] = dn;                         has[1] = has_dn;
            nb[2] = c > 0 ? line_mem[slot(lr, c - 1)] : '0;
            has[2] = c > 0;
            nb[3] = (c + 1 < cols) ? line_mem[slot(lr, c + 1)] : '0;
            has[3] = c + 1 < cols;
            rec.row  = lr[9:0];
            rec.col  = c[10:0];
            rec.lbl  = classify(line_mem[slot(lr, c)], nb, has);
            rec.last = last;
            return rec;
        endfunction

        // Called for every accepted request
        function void note_request(logic op, logic [S_TDATA_W-1:0] d);
            int unsigned rows, cols;
            bit          wrap;
            rows = rows_reg == 0 ? 1 : rows_reg;
            cols = cols_reg == 0 ? 1 : cols_reg;
            if (rows > NROWS) rows = NROWS;
            if (cols > NCOLS) cols = NCOLS;
            wrap = col_cnt + 1 >= cols;
            if (op == OP_PIXEL) begin
                if (row_cnt >= rows) return;
                if (row_cnt > 0)
                    queue_label(label_pixel(row_cnt - 1, col_cnt, cols, 1, d[50:0], 0));
                line_mem[slot(row_cnt, col_cnt)] = d[50:0];
                if (wrap) begin
                    col_cnt = 0;
                    row_cnt++;
                end else begin
                    col_cnt++;
                end
            end else begin
                if (row_cnt < rows) return;
                queue_label(label_pixel(row_cnt - 1, col_cnt, cols, 0, '0, wrap));
                if (wrap) begin
                    col_cnt = 0;
                    row_cnt = 0;
                end else begin
                    col_cnt++;
                end
            end
        endfunction

        function void check_label(logic [M_TDATA_W-1:0] d, logic lst);
            label_rec_t got, exp;
            got.row  = d[9:0];
            got.col  = d[20:10];
            got.lbl  = label_t'(d[23:21]);
            got.last = lst;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected label: row %0d col %0d label %0d last %0b",
                             got.row, got.col, got.lbl, got.last);
                return;
            end
            exp = pending.pop_front();
            if (got.row !== exp.row || got.col !== exp.col || got.lbl !== exp.lbl
                    || got.last !== exp.last) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("label mismatch: expected row %0d col %0d label %0d last %0b, got row %0d col %0d label %0d last %0b",
                             exp.row, exp.col, exp.lbl, exp.last,
                             got.row, got.col, got.lbl, got.last);
            end
        endfunction
    endclass

    logic                   aclk = 0;
    logic                   aresetn = 0;
    logic                   s_tvalid = 0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata = '0;
    logic [0:0]             s_tuser = '0;
    logic                   m_tvalid;
    logic                   m_tready = 0;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic                   m_tlast;
    logic                   cfg_valid = 0;
    logic                   cfg_ready;
    logic [CFG_AW-1:0]      cfg_addr = '0;
    logic [CFG_DW-1:0]      cfg_wdata = '0;

    label_scoreboard sb = new();
    bit              calm;          // no source gaps in this frame
    int              rand_items;
    int              idle_cycles;
    int              stall_left;
    int              stall_pick;
    int              base_x, base_y, base_z;

    range_image_edge_classifier_core i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #6 aclk = 1;
        #6 aclk = 0;
    end

    // Monitors: requests feed the predictor, labels are checked
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) sb.note_request(s_tuser[0], s_tdata);
        if (aresetn && m_tvalid && m_tready) sb.check_label(m_tdata, m_tlast);
    end

    // Sink back pressure: mostly short stalls, a few long ones, calm stretches
    always @(posedge aclk) begin
        if (stall_left == 0) begin
            stall_pick = $urandom_range(0, 99);
            if (stall_pick < 55) begin
                m_tready <= 1;
                stall_left = $urandom_range(1, 40);
            end else if (stall_pick < 92) begin
                m_tready <= 0;
                stall_left = $urandom_range(1, 3);
            end else begin
                m_tready <= 0;
                stall_left = $urandom_range(10, 60);
            end
        end else begin
            stall_left--;
        end
    end

    // Watchdog on cycles without any handshake
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)
                || !aresetn)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles == IDLE_LIMIT) begin
            $display("range_image_edge_classifier_core_test failed");
            $finish;
        end
    end

    function automatic logic [S_TDATA_W-1:0] make_px(int x, int y, int z, bit v, int cls);
        logic [15:0] xs, ys, zs;
        logic [1:0]  cs;
        xs = x[15:0];
        ys = y[15:0];
        zs = z[15:0];
        cs = cls[1:0];
        return {5'd0, cs, v, zs, ys, xs};
    endfunction

    // Mostly a smooth surface with jitter and jumps, sometimes anything
    function automatic logic [S_TDATA_W-1:0] rand_px(int c);
        int roll, cls;
        roll = $urandom_range(0, 99);
        cls = $urandom_range(0, 99) < 70 ? 0 : $urandom_range(1, 3);
        if (roll < 10)
            return make_px($urandom, $urandom, $urandom, $urandom_range(0, 1), $urandom);
        if (roll < 20) begin
            base_x += $urandom_range(0, 600) - 300;
            base_z += $urandom_range(0, 600) - 300;
        end
        return make_px(base_x + c * 5 + $urandom_range(0, 60) - 30,
                       base_y + $urandom_range(0, 60) - 30,
                       base_z + $urandom_range(0, 60) - 30,
                       $urandom_range(0, 99) < 92, cls);
    endfunction

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (calm || roll < 60) return 0;
        if (roll < 92) return $urandom_range(1, 3);
        return $urandom_range(5, 40);
    endfunction

    task automatic send_req(logic op, logic [S_TDATA_W-1:0] d);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1;
        s_tuser  <= op;
        s_tdata  <= d;
        do @(posedge aclk); while (!s_tready);
    endtask

    // Let every expected label arrive, then let the pipeline empty
    task automatic drain();
        s_tvalid <= 0;
        @(posedge aclk);
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
    endtask

    task automatic write_regs(int rows, int cols, int vf, int hf, int be, int mt);
        logic [CFG_AW-1:0] idx [6];
        int                val [6];
        idx = '{REG_ROWS_IN_USE, REG_COLS_IN_USE, REG_VERTICAL_FACTOR,
                REG_HORIZONTAL_FACTOR, REG_BASE_ERROR, REG_MAX_THRESHOLD};
        val = '{rows, cols, vf, hf, be, mt};
        for (int i = 0; i < 6; i++) begin
            cfg_valid <= 1;
            cfg_addr  <= idx[i];
            cfg_wdata <= val[i][15:0];
            do @(posedge aclk); while (!cfg_ready);
            sb.set_reg(idx[i], val[i][15:0]);
        end
        cfg_valid <= 0;
    endtask

    // One frame with random content; noise adds requests the block ignores
    task automatic run_frame(bit noise);
        int rows, cols;
        rows = sb.rows_reg == 0 ? 1 : (sb.rows_reg > NROWS ? NROWS : sb.rows_reg);
        cols = sb.cols_reg == 0 ? 1 : (sb.cols_reg > NCOLS ? NCOLS : sb.cols_reg);
        calm = $urandom_range(0, 3) == 0;
        base_x = $urandom_range(0, 8000) - 4000;
        base_y = $urandom_range(0, 8000) - 4000;
        base_z = $urandom_range(0, 400) - 200;
        for (int r = 0; r < rows; r++) begin
            for (int c = 0; c < cols; c++) begin
                if (noise && $urandom_range(0, 99) < 3) send_req(OP_FLUSH, rand_px(c));
                send_req(OP_PIXEL, rand_px(c));
                rand_items++;
            end
        end
        for (int c = 0; c < cols; c++) begin
            if (noise && $urandom_range(0, 99) < 3) send_req(OP_PIXEL, rand_px(c));
            send_req(OP_FLUSH, S_TDATA_W'($urandom));
            rand_items++;
        end
    endtask

    initial begin
        logic [S_TDATA_W-1:0] dir_px [12];
        rand_items = 0;
        idle_cycles = 0;
        stall_left = 0;
        repeat (8) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // Directed: field extremes, all classes, blocked neighbors, big jumps
        dir_px = '{make_px(-32768, 32767, -32768, 1, 0), make_px(32767, -32768, 32767, 1, 3),
                   make_px(0, 0, 0, 1, 0),               make_px(10, 10, 10, 0, 0),
                   make_px(-32768, -32768, 0, 1, 0),     make_px(100, 0, 0, 1, 1),
                   make_px(100, 5, 0, 1, 2),             make_px(-1, -1, -1, 1, 3),
                   make_px(32767, 32767, 32767, 1, 0),   make_px(0, 0, 0, 0, 3),
                   make_px(200, 200, 0, 1, 0),           make_px(205, 200, 0, 1, 0)};
        write_regs(3, 4, 65535, 0, 0, 65535);
        calm = 0;
        send_req(OP_FLUSH, '0);                 // flush before the frame is in
        for (int i = 0; i < 12; i++) send_req(OP_PIXEL, dir_px[i]);
        send_req(OP_PIXEL, dir_px[0]);          // pixel after the frame is in
        for (int i = 0; i < 4; i++) send_req(OP_FLUSH, '0);
        drain();

        // Zero geometry acts as one pixel; zero threshold with no neighbor
        write_regs(0, 0, 0, 0, 0, 0);
        send_req(OP_PIXEL, make_px(5, 5, 5, 1, 0));
        send_req(OP_FLUSH, '0);
        drain();
        // Crossed clamps
        write_regs(2, 3, 256, 256, 500, 10);
        run_frame(1);
        drain();
        // Oversized row count clamps to the maximum
        write_regs(2047, 1, 65535, 65535, 65535, 65535);
        run_frame(0);
        drain();

        // Random settings, mostly small frames
        rand_items = 0;
        while (rand_items < ITEM_GOAL) begin
            write_regs($urandom_range(1, 8), $urandom_range(1, 40),
                       $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(64, 1024),
                       $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(64, 1024),
                       $urandom_range(0, 4) == 0 ? $urandom : $urandom_range(0, 100),
                       $urandom_range(0, 4) == 0 ? $urandom : $urandom_range(50, 2000));
            repeat ($urandom_range(1, 3)) run_frame(1);
            drain();
        end

        if (sb.pending.size() != 0) begin
            sb.mismatches++;
            $display("%0d labels never arrived", sb.pending.size());
        end
        if (sb.mismatches == 0)
            $display("range_image_edge_classifier_core_test passed");
        else
            $display("range_image_edge_classifier_core_test failed");
        $finish;
    end

endmodule
